// ===== hw/rtl/sdiv_pkg.sv =====
// Shared types and constants for the signed 64-by-32 saturating divider.
// No dependencies; every other file in hw/rtl refers to it by scoped name.
`timescale 1ns / 1ps

package sdiv_pkg;

   localparam int unsigned DVD_WIDTH = 64;
   localparam int unsigned DVS_WIDTH = 32;
   localparam int unsigned STEPS     = 32;

   localparam logic [DVS_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [DVS_WIDTH-1:0] DVS_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [DVS_WIDTH-1:0] rem;
      logic [DVS_WIDTH-1:0] quo;
      logic [DVS_WIDTH-1:0] dvs_mag;
      logic                 neg;
      logic                 sat;
      logic [DVD_WIDTH-1:0] mag;
   } stage_type;

endpackage

// ===== hw/rtl/sdiv_prep.sv =====
// Front end: input register, operand magnitudes, saturation check.
// Depends on sdiv_pkg; feeds the first division step.
`timescale 1ns / 1ps

module sdiv_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           req_valid,
   input  logic signed [sdiv_pkg::DVD_WIDTH-1:0] req_dividend,
   input  logic signed [sdiv_pkg::DVS_WIDTH-1:0] req_divisor,
   output logic                           out_valid,
   output sdiv_pkg::stage_type            out_stage
);

   logic                           in_valid_ff;
   logic [sdiv_pkg::DVD_WIDTH-1:0] dividend_ff;
   logic [sdiv_pkg::DVS_WIDTH-1:0] divisor_ff;

   logic                           mag_valid_ff;
   logic [sdiv_pkg::DVD_WIDTH-1:0] mag_ff;
   logic [sdiv_pkg::DVD_WIDTH-1:0] mag_in;
   logic [sdiv_pkg::DVS_WIDTH-1:0] dvs_mag_ff;
   logic [sdiv_pkg::DVS_WIDTH-1:0] dvs_mag_in;
   logic                           neg_ff;
   logic                           neg_in;

   logic                           stage_valid_ff;
   sdiv_pkg::stage_type            stage_ff;
   sdiv_pkg::stage_type            stage_in;
   logic [sdiv_pkg::DVS_WIDTH-1:0] hi;

   // negate on the sign of each operand
   always_comb begin
      mag_in     = dividend_ff[sdiv_pkg::DVD_WIDTH-1] ? (~dividend_ff + 64'd1) : dividend_ff;
      dvs_mag_in = divisor_ff[sdiv_pkg::DVS_WIDTH-1] ? (~divisor_ff + 32'd1) : divisor_ff;
      neg_in     = dividend_ff[sdiv_pkg::DVD_WIDTH-1] ^ divisor_ff[sdiv_pkg::DVS_WIDTH-1];
   end

   // saturate on overflow, zero divisor, or most-negative divisor with small dividend
   always_comb begin
      hi                = mag_ff[sdiv_pkg::DVD_WIDTH-1:sdiv_pkg::DVS_WIDTH];
      stage_in.rem      = hi;
      stage_in.quo      = mag_ff[sdiv_pkg::DVS_WIDTH-1:0];
      stage_in.dvs_mag  = dvs_mag_ff;
      stage_in.neg      = neg_ff;
      stage_in.sat      = (hi >= dvs_mag_ff) ||
                          ((hi == '0) && (dvs_mag_ff == sdiv_pkg::DVS_MIN));
      stage_in.mag      = mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         mag_valid_ff   <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff    <= req_valid;
         mag_valid_ff   <= in_valid_ff;
         stage_valid_ff <= mag_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dividend_ff <= req_dividend;
         divisor_ff  <= req_divisor;
         mag_ff      <= mag_in;
         dvs_mag_ff  <= dvs_mag_in;
         neg_ff      <= neg_in;
         stage_ff    <= stage_in;
      end
   end

   assign out_valid = stage_valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hw/rtl/sdiv_step.sv =====
// One restoring-division step: shift in one dividend bit, trial subtract, register.
// Depends on sdiv_pkg; instantiated once per quotient bit.
`timescale 1ns / 1ps

module sdiv_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  sdiv_pkg::stage_type in_stage,
   output logic                out_valid,
   output sdiv_pkg::stage_type out_stage
);

   logic                           valid_ff;
   sdiv_pkg::stage_type            stage_ff;
   sdiv_pkg::stage_type            stage_in;
   logic [sdiv_pkg::DVS_WIDTH:0]   partial;
   logic [sdiv_pkg::DVS_WIDTH:0]   trial;

   always_comb begin
      partial  = {in_stage.rem, in_stage.quo[sdiv_pkg::DVS_WIDTH-1]};
      trial    = partial - {1'b0, in_stage.dvs_mag};
      stage_in = in_stage;
      if (!trial[sdiv_pkg::DVS_WIDTH]) begin
         stage_in.rem = trial[sdiv_pkg::DVS_WIDTH-1:0];
         stage_in.quo = {in_stage.quo[sdiv_pkg::DVS_WIDTH-2:0], 1'b1};
      end else begin
         stage_in.rem = partial[sdiv_pkg::DVS_WIDTH-1:0];
         stage_in.quo = {in_stage.quo[sdiv_pkg::DVS_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hw/rtl/sdiv_out.sv =====
// Back end: saturation select, sign, output register with skid beat.
// Depends on sdiv_pkg; drives the rsp_ channel and the pipeline advance.
`timescale 1ns / 1ps

module sdiv_out (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  sdiv_pkg::stage_type            in_stage,
   output logic                           advance,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [sdiv_pkg::DVS_WIDTH-1:0] rsp_quotient,
   output logic [sdiv_pkg::DVD_WIDTH-1:0] rsp_dividend_magnitude
);

   logic [sdiv_pkg::DVS_WIDTH-1:0] q_abs;
   logic [sdiv_pkg::DVS_WIDTH-1:0] q_new;

   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [sdiv_pkg::DVS_WIDTH-1:0] out_q_ff;
   logic [sdiv_pkg::DVS_WIDTH-1:0] out_q_in;
   logic [sdiv_pkg::DVD_WIDTH-1:0] out_mag_ff;
   logic [sdiv_pkg::DVD_WIDTH-1:0] out_mag_in;

   logic                           skid_valid_ff;
   logic                           skid_valid_in;
   logic [sdiv_pkg::DVS_WIDTH-1:0] skid_q_ff;
   logic [sdiv_pkg::DVS_WIDTH-1:0] skid_q_in;
   logic [sdiv_pkg::DVD_WIDTH-1:0] skid_mag_ff;
   logic [sdiv_pkg::DVD_WIDTH-1:0] skid_mag_in;

   logic                           take;
   logic                           arrive;

   always_comb begin
      q_abs = in_stage.sat ? sdiv_pkg::SAT_POS : in_stage.quo;
      q_new = in_stage.neg ? (~q_abs + 32'd1) : q_abs;
   end

   assign advance = !skid_valid_ff;
   assign take    = out_valid_ff && !rsp_stall;
   assign arrive  = in_valid && advance;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_q_in      = out_q_ff;
      out_mag_in    = out_mag_ff;
      skid_valid_in = skid_valid_ff;
      skid_q_in     = skid_q_ff;
      skid_mag_in   = skid_mag_ff;
      if (skid_valid_ff) begin
         // drain the skid beat once the output beat leaves
         if (take) begin
            out_q_in      = skid_q_ff;
            out_mag_in    = skid_mag_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_q_in     = q_new;
            out_mag_in   = in_stage.mag;
         end else begin
            skid_valid_in = 1'b1;
            skid_q_in     = q_new;
            skid_mag_in   = in_stage.mag;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_q_ff    <= out_q_in;
      out_mag_ff  <= out_mag_in;
      skid_q_ff   <= skid_q_in;
      skid_mag_ff <= skid_mag_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_quotient           = out_q_ff;
   assign rsp_dividend_magnitude = out_mag_ff;

endmodule

// ===== hw/rtl/signed_div_64_by_32_saturating.sv =====
// Signed 64-by-32 saturating divider, fully pipelined: one operand pair per cycle.
// Depends on sdiv_pkg, sdiv_prep, sdiv_step and sdiv_out.
//
// Each beat on req_ yields exactly one beat on rsp_, in order. Past the input register
// that accepts it come one magnitude stage, one saturation-check stage, 32
// restoring-division stages (one quotient bit each) and the output register.
// A new pair is taken every cycle; the output side holds one extra skid beat, and the
// input stalls while that skid beat is occupied, which happens only after a response
// has been stalled with another beat right behind it.
// Quotients that do not fit saturate to +/-0x7FFFFFFF; the dividend magnitude
// is returned alongside.
`timescale 1ns / 1ps

module signed_div_64_by_32_saturating (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [sdiv_pkg::DVD_WIDTH-1:0] req_dividend,
   input  logic signed [sdiv_pkg::DVS_WIDTH-1:0] req_divisor,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [sdiv_pkg::DVS_WIDTH-1:0] rsp_quotient,
   output logic [sdiv_pkg::DVD_WIDTH-1:0] rsp_dividend_magnitude
);

   logic                advance;
   logic                step_valid [sdiv_pkg::STEPS+1];
   sdiv_pkg::stage_type step_stage [sdiv_pkg::STEPS+1];

   assign req_stall = !advance;

   sdiv_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_valid    (req_valid),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .out_valid    (step_valid[0]),
      .out_stage    (step_stage[0])
   );

   for (genvar i = 0; i < sdiv_pkg::STEPS; i++) begin : g_step
      sdiv_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (step_valid[i]),
         .in_stage  (step_stage[i]),
         .out_valid (step_valid[i+1]),
         .out_stage (step_stage[i+1])
      );
   end

   sdiv_out u_out (
      .clock                  (clock),
      .reset                  (reset),
      .in_valid               (step_valid[sdiv_pkg::STEPS]),
      .in_stage               (step_stage[sdiv_pkg::STEPS]),
      .advance                (advance),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_quotient           (rsp_quotient),
      .rsp_dividend_magnitude (rsp_dividend_magnitude)
   );

endmodule

// ===== sim/sdiv_quotient_checker.sv =====
// Watches both channels of the signed 64-by-32 saturating divider, predicts each beat
// and compares it field by field. Depends on sdiv_pkg for widths and saturation constants.
`timescale 1ns / 1ps

module sdiv_quotient_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [sdiv_pkg::DVD_WIDTH-1:0]    req_dividend,
   input  logic [sdiv_pkg::DVS_WIDTH-1:0]    req_divisor,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [sdiv_pkg::DVS_WIDTH-1:0]    rsp_quotient,
   input  logic [sdiv_pkg::DVD_WIDTH-1:0]    rsp_dividend_magnitude,
   output int                                fail_count,
   output int                                backlog,
   output int                                beats_checked
);

   typedef struct {
      logic [sdiv_pkg::DVS_WIDTH-1:0] quotient;
      logic [sdiv_pkg::DVD_WIDTH-1:0] magnitude;
   } div_result_type;

   div_result_type expected_results[$];

   function automatic div_result_type divide_saturating(input logic [63:0] dividend,
                                                        input logic [31:0] divisor);
      logic        flip;
      logic [63:0] mag;
      logic [63:0] wide;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] dmag;
      logic [31:0] q;
      div_result_type res;
      flip = dividend[63] ^ divisor[31];
      mag  = dividend[63] ? -dividend : dividend;
      hi   = mag[63:32];
      lo   = mag[31:0];
      dmag = divisor[31] ? -divisor : divisor;
      if (hi == '0) begin
         if (dmag == '0 || dmag == sdiv_pkg::DVS_MIN)
            q = sdiv_pkg::SAT_POS;
         else
            q = lo / dmag;
         q = flip ? -q : q;
      end else if (hi >= dmag) begin
         q = flip ? -sdiv_pkg::SAT_POS : sdiv_pkg::SAT_POS;
      end else begin
         wide = mag / {32'd0, dmag};
         q    = wide[31:0];
         q    = flip ? -q : q;
      end
      res.quotient  = q;
      res.magnitude = mag;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      div_result_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         expected_results.delete();
         fail_count    <= 0;
         backlog       <= 0;
         beats_checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected beat: quotient %h, dividend_magnitude %h",
                      rsp_quotient, rsp_dividend_magnitude);
               errs++;
            end else begin
               want = expected_results.pop_front();
               beats_checked <= beats_checked + 1;
               if (rsp_quotient !== want.quotient) begin
                  $error("quotient: expected %h, actual %h", want.quotient, rsp_quotient);
                  errs++;
               end
               if (rsp_dividend_magnitude !== want.magnitude) begin
                  $error("dividend_magnitude: expected %h, actual %h",
                         want.magnitude, rsp_dividend_magnitude);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(divide_saturating(req_dividend, req_divisor));
         fail_count <= fail_count + errs;
         backlog    <= expected_results.size();
      end
   end

endmodule

// ===== sim/tb_signed_div_64_by_32_saturating.sv =====
// Top of the divider testbench: clock, reset, stimulus, idle profiles, watchdog, verdict.
// Depends on sdiv_pkg, signed_div_64_by_32_saturating and sdiv_quotient_checker.
`timescale 1ns / 1ps

module tb_signed_div_64_by_32_saturating;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 160;
   localparam int PHASE_BEATS    = 280;
   localparam int FLOOD_BEATS    = 120;
   localparam int SETTLE_CYCLES  = 40;

   logic                                    clock;
   logic                                    reset = 1'b1;
   logic                                    req_valid;
   logic                                    req_stall;
   logic signed [sdiv_pkg::DVD_WIDTH-1:0]   req_dividend;
   logic signed [sdiv_pkg::DVS_WIDTH-1:0]   req_divisor;
   logic                                    rsp_valid;
   logic                                    rsp_stall;
   logic signed [sdiv_pkg::DVS_WIDTH-1:0]   rsp_quotient;
   logic [sdiv_pkg::DVD_WIDTH-1:0]          rsp_dividend_magnitude;

   int fail_count;
   int backlog;
   int beats_checked;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit holdoff_go    = 1'b0;
   int idle_cycles   = 0;
   int directed_sent = 0;
   int random_sent   = 0;

   signed_div_64_by_32_saturating u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_dividend           (req_dividend),
      .req_divisor            (req_divisor),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_quotient           (rsp_quotient),
      .rsp_dividend_magnitude (rsp_dividend_magnitude)
   );

   sdiv_quotient_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_dividend           (req_dividend),
      .req_divisor            (req_divisor),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_quotient           (rsp_quotient),
      .rsp_dividend_magnitude (rsp_dividend_magnitude),
      .fail_count             (fail_count),
      .backlog                (backlog),
      .beats_checked          (beats_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // hold off the response side for a long stretch on request, else stall at random
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_go) begin
            holdoff_go = 1'b0;
            for (int i = 0; i < HOLDOFF_CYCLES; i++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL signed_div_64_by_32_saturating");
            $finish;
         end
      end
   end

   task automatic send_pair(input logic [63:0] dvd, input logic [31:0] dvs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_dividend <= dvd;
      req_divisor  <= dvs;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (backlog == 0);
      @(negedge clock);
   endtask

   function automatic void random_pair(output logic [63:0] dvd, output logic [31:0] dvs);
      logic [31:0] hi;
      logic [31:0] dmag;
      logic [63:0] mag;
      int          kind;
      kind = $urandom_range(99);
      dvs  = $urandom;
      dvd  = {$urandom, $urandom};
      if (kind < 25) begin
         dvd = {$urandom, $urandom};
      end else if (kind < 45) begin
         mag = {32'd0, $urandom};
         dvd = $urandom_range(1) ? -mag : mag;
         if ($urandom_range(3) == 0)
            dvs = $urandom_range(15, 1);
         if ($urandom_range(1))
            dvs = -dvs;
      end else if (kind < 80) begin
         dmag = $urandom_range(32'h8000_0000, 2);
         hi   = $urandom_range(dmag - 1, 1);
         mag  = {hi, $urandom};
         dvd  = $urandom_range(1) ? -mag : mag;
         dvs  = $urandom_range(1) ? -dmag : dmag;
      end else if (kind < 92) begin
         dmag = $urandom_range(32'h7FFF_FFFF, 0);
         hi   = $urandom_range(32'h7FFF_FFFF, (dmag == 0) ? 1 : dmag);
         mag  = {hi, $urandom};
         dvd  = $urandom_range(1) ? -mag : mag;
         dvs  = $urandom_range(1) ? -dmag : dmag;
      end else begin
         case ($urandom_range(4))
            0:       dvs = '0;
            1:       dvs = sdiv_pkg::DVS_MIN;
            2:       dvs = 32'd1;
            3:       dvs = -32'sd1;
            default: dvs = sdiv_pkg::SAT_POS;
         endcase
         if ($urandom_range(1))
            dvd = {{32{1'b0}}, $urandom};
         if ($urandom_range(1))
            dvd = -dvd;
      end
   endfunction

   task automatic run_directed();
      logic [63:0] dvd_list[22];
      logic [31:0] dvs_list[22];
      dvd_list = '{64'd0, 64'd0, 64'd100, -64'sd100, 64'd100,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0000, -64'sd1, 64'h0000_0000_FFFF_FFFF,
                   64'h0000_0000_FFFF_FFFF, 64'h0000_0000_8000_0000,
                   64'h0000_0001_0000_0000, 64'h7FFF_FFFE_FFFF_FFFF,
                   -64'sh3_1234_5678, 64'h0000_0005_0000_0000,
                   64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'hFFFF_FFFF_0000_0000, -64'sd1};
      dvs_list = '{32'd1, 32'd0, 32'd0, 32'd0, sdiv_pkg::DVS_MIN,
                   32'd1, -32'sd1, 32'd1, 32'd1, 32'd1, -32'sd1, 32'd1,
                   32'd2, sdiv_pkg::SAT_POS, -32'sd7, 32'd5, 32'd0,
                   sdiv_pkg::SAT_POS, sdiv_pkg::DVS_MIN, sdiv_pkg::DVS_MIN,
                   32'd3, -32'sd1};
      foreach (dvd_list[i]) begin
         send_pair(dvd_list[i], dvs_list[i]);
         directed_sent++;
      end
   endtask

   task automatic run_random(input int count);
      logic [63:0] dvd;
      logic [31:0] dvs;
      for (int i = 0; i < count; i++) begin
         random_pair(dvd, dvs);
         send_pair(dvd, dvs);
         random_sent++;
      end
   endtask

   initial begin
      int send_profile[4];
      int stall_profile[4];
      send_profile  = '{0, 63, 0, 23};
      stall_profile = '{0, 0, 63, 23};
      req_valid    = 1'b0;
      req_dividend = '0;
      req_divisor  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      drain();

      foreach (send_profile[p]) begin
         send_idle_pct = send_profile[p];
         stall_pct     = stall_profile[p];
         run_random(PHASE_BEATS);
         drain();
         if (p == 0) begin
            holdoff_go = 1'b1;
            run_random(FLOOD_BEATS);
            drain();
         end
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (backlog != 0)
         $error("%0d predicted beats never arrived", backlog);
      $display("Covered %0d directed and %0d random operand pairs, %0d result beats checked,",
               directed_sent, random_sent, beats_checked);
      $display("under four idle/stall profiles plus one long response hold-off.");
      if (fail_count == 0 && backlog == 0)
         $display("PASS signed_div_64_by_32_saturating");
      else
         $display("FAIL signed_div_64_by_32_saturating");
      $finish;
   end

endmodule

// ===== signed_div_64_by_32_saturating.f =====
hw/rtl/sdiv_pkg.sv
hw/rtl/sdiv_prep.sv
hw/rtl/sdiv_step.sv
hw/rtl/sdiv_out.sv
hw/rtl/signed_div_64_by_32_saturating.sv
sim/sdiv_quotient_checker.sv
sim/tb_signed_div_64_by_32_saturating.sv
